[design/modulated_delay_chorus_assert.svh]
// assertion macros shared by the chorus rtl
`ifndef MODULATED_DELAY_CHORUS_ASSERT_SVH
`define MODULATED_DELAY_CHORUS_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MDC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define MDC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/mdc_pkg.sv]
// shared types, constants and table function for the chorus
package mdc_pkg;

	localparam int DELAY_WORDS_DEF          = 2048;
	localparam int SAMPLE_BITS_DEF          = 24;
	localparam int SINE_QUARTER_ENTRIES_DEF = 256;

	localparam int PHASE_STEP_W = 23;
	localparam int MOD_DEPTH_W  = 16;
	localparam int BASE_DELAY_W = 10;
	localparam int CFG_DATA_W   = 23;
	localparam int CFG_IDX_W    = 2;

	localparam logic [PHASE_STEP_W-1:0] PHASE_STEP_RST = 23'd89478;
	localparam logic [MOD_DEPTH_W-1:0]  MOD_DEPTH_RST  = 16'd16384;
	localparam logic [BASE_DELAY_W-1:0] BASE_DELAY_RST = 10'd480;

	localparam int SINE_W = 15;
	localparam int LFO_W  = 16;
	localparam int FACTOR_W = 32;
	localparam logic signed [33:0] FACTOR_ONE = 34'sh0_4000_0000;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	localparam int W_DRY     = 22938;
	localparam int W_WET     = 9830;
	localparam int MIX_ROUND = 16384;
	localparam int MIX_SHIFT = 15;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PHASE_STEP = 2'd0,
		REG_MOD_DEPTH  = 2'd1,
		REG_BASE_DELAY = 2'd2
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INDEX,
		ST_LFO,
		ST_FACTOR,
		ST_DELAY,
		ST_REDUCE,
		ST_READ,
		ST_WRITE,
		ST_MIX,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mix_stat_t;

	// quarter-wave sine entry in q15 from an angle in q30, taylor series to x^13
	function automatic logic [SINE_W-1:0] sine_from_x(input longint unsigned x);
		longint unsigned x2;
		longint unsigned term;
		longint sum;
		longint unsigned scaled;
		x2   = (x * x) >> 30;
		term = x;
		sum  = longint'(x);
		term = ((term * x2) >> 30) / 64'd6;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd20;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd42;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd72;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd110;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd156;
		sum  = sum + longint'(term);
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > 64'sd1073741824) begin
			sum = 64'sd1073741824;
		end
		scaled = (longint'(unsigned'(sum)) * 64'd32767 + 64'd536870912) >> 30;
		return scaled[SINE_W-1:0];
	endfunction

endpackage

[design/mdc_if.sv]
// valid/ready stream interfaces for dry and mixed samples
interface mdc_in_if #(
	parameter int W = mdc_pkg::SAMPLE_BITS_DEF
) ();
	logic         valid;
	logic         ready;
	logic [W-1:0] in_sample;

	modport source (output valid, output in_sample, input ready);
	modport sink (input valid, input in_sample, output ready);
endinterface

interface mdc_out_if #(
	parameter int W = mdc_pkg::SAMPLE_BITS_DEF
) ();
	logic         valid;
	logic         ready;
	logic [W-1:0] out_sample;

	modport source (output valid, output out_sample, input ready);
	modport sink (input valid, input out_sample, output ready);
endinterface

[design/mdc_serial_mix.sv]
// bit-serial dry/wet mixer: msb-first shift-add of both samples against q15 weights
`include "modulated_delay_chorus_assert.svh"
module mdc_serial_mix #(
	parameter int SAMPLE_BITS = mdc_pkg::SAMPLE_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [SAMPLE_BITS-1:0]  dry,
	input  logic [SAMPLE_BITS-1:0]  wet,
	output mdc_pkg::mix_stat_t      stat,
	output logic [SAMPLE_BITS-1:0]  result
);
	import mdc_pkg::*;

	localparam int ACC_W = SAMPLE_BITS + 16;
	localparam int CNT_W = $clog2(SAMPLE_BITS);

	logic [SAMPLE_BITS-1:0]  dry_sr_q;
	logic [SAMPLE_BITS-1:0]  wet_sr_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    busy_q;
	logic                    first_q;
	logic                    done_q;

	logic signed [ACC_W-1:0] partial;
	logic signed [ACC_W-1:0] acc_next;
	logic signed [ACC_W-1:0] rounded;

	always_comb begin
		partial = '0;
		if (dry_sr_q[SAMPLE_BITS-1]) begin
			partial = partial + ACC_W'(W_DRY);
		end
		if (wet_sr_q[SAMPLE_BITS-1]) begin
			partial = partial + ACC_W'(W_WET);
		end
		// the sign bit carries negative weight
		acc_next = (acc_q <<< 1) + (first_q ? -partial : partial);
	end

	assign rounded = acc_q + ACC_W'(MIX_ROUND);
	assign result  = rounded[MIX_SHIFT +: SAMPLE_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(SAMPLE_BITS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dry_sr_q <= dry;
			wet_sr_q <= wet;
			acc_q    <= '0;
			first_q  <= 1'b1;
		end else if (busy_q) begin
			dry_sr_q <= dry_sr_q << 1;
			wet_sr_q <= wet_sr_q << 1;
			acc_q    <= acc_next;
			first_q  <= 1'b0;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;

	`MDC_ASSERT_NOW(a_no_restart, start, !busy_q, "mix restarted while busy")
	`MDC_ASSERT_NEXT(a_done_ends_run, busy_q && cnt_q == '0 && !start, done_q && !busy_q,
		"mix did not finish after last bit")
	`MDC_ASSERT_NOW(a_done_idle, done_q, !busy_q, "done raised while still shifting")

endmodule

[design/modulated_delay_chorus.sv]
// Mono chorus: each dry sample is mixed 0.7/0.3 with a copy read from a delay line whose
// tap is swept by a quarter-wave sine lfo. One request is worked on at a time: the request
// is taken, the lfo table is read and the depth multiplied in, a bit-serial multiply over
// base_delay gives the delay and modulo reduction brings it into the line. The delay memory
// is then read and written on its single port, the bit-serial mixer runs and the output
// register is loaded. A new request is taken while the previous result waits in the output
// register. The delay memory needs no clearing pass: a fill mark makes words never written
// read as zero, so requests are taken straight out of reset.
`include "modulated_delay_chorus_assert.svh"
module modulated_delay_chorus #(
	parameter int DELAY_WORDS          = mdc_pkg::DELAY_WORDS_DEF,
	parameter int SAMPLE_BITS          = mdc_pkg::SAMPLE_BITS_DEF,
	parameter int SINE_QUARTER_ENTRIES = mdc_pkg::SINE_QUARTER_ENTRIES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr,
	input  logic [mdc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [mdc_pkg::CFG_DATA_W-1:0] cfg_data,
	mdc_in_if.sink                         samples,
	mdc_out_if.source                      mixed
);
	import mdc_pkg::*;

	localparam int AW    = $clog2(DELAY_WORDS);
	localparam int DLY_W = AW + 2;
	localparam int IW    = $clog2(SINE_QUARTER_ENTRIES + 1);
	localparam int IPW   = 30 + IW;
	localparam int PRODW = BASE_DELAY_W + FACTOR_W;
	localparam int BCW   = $clog2(BASE_DELAY_W);

	// configuration
	logic [PHASE_STEP_W-1:0] phase_step_q;
	logic [MOD_DEPTH_W-1:0]  mod_depth_q;
	logic [BASE_DELAY_W-1:0] base_delay_q;

	// control
	state_t         state_q;
	state_t         state_d;
	logic [31:0]    phase_q;
	logic [AW-1:0]  wptr_q;
	logic           wrapped_q;
	logic           out_valid_q;
	logic [BCW-1:0] bcnt_q;

	// datapath
	logic [SAMPLE_BITS-1:0]  dry_q;
	logic [IW-1:0]           idx_q;
	logic                    neg_q;
	logic signed [LFO_W-1:0] lfo_q;
	logic [FACTOR_W-1:0]     factor_q;
	logic [BASE_DELAY_W-1:0] base_sr_q;
	logic [PRODW-1:0]        prod_q;
	logic [DLY_W-1:0]        delay_q;
	logic [SAMPLE_BITS-1:0]  rdata_q;
	logic                    rvalid_q;
	logic [SAMPLE_BITS-1:0]  out_data_q;
	logic [SAMPLE_BITS-1:0]  mem [DELAY_WORDS];

	// outputs of the sequencer
	logic in_ready;
	logic mix_start;
	logic out_load;

	logic [SINE_W-1:0]       sine_rom [SINE_QUARTER_ENTRIES + 1];
	logic [IPW-1:0]          idx_prod;
	logic [IW-1:0]           idx_raw;
	logic signed [32:0]      lfo_prod;
	logic signed [33:0]      factor_sum;
	logic [PRODW-1:0]        prod_next;
	logic [AW:0]             rd_sum;
	logic [AW-1:0]           rd_addr;
	logic                    out_free;
	logic                    delay_big;
	logic [SAMPLE_BITS-1:0]  wet_word;
	logic [SAMPLE_BITS-1:0]  mix_result;
	mix_stat_t               mix_stat;

	for (genvar k = 0; k <= SINE_QUARTER_ENTRIES; k++) begin : g_rom
		localparam longint unsigned XK =
			(longint'(k) * HALF_PI_Q30) / SINE_QUARTER_ENTRIES;
		assign sine_rom[k] = sine_from_x(XK);
	end

	assign idx_prod   = IPW'(phase_q[29:0]) * IPW'(SINE_QUARTER_ENTRIES);
	assign idx_raw    = idx_prod[30 +: IW];
	assign lfo_prod   = lfo_q * $signed({1'b0, mod_depth_q});
	assign factor_sum = FACTOR_ONE + 34'(lfo_prod);
	assign prod_next  = (prod_q << 1) + (base_sr_q[BASE_DELAY_W-1] ? PRODW'(factor_q) : '0);
	assign delay_big  = delay_q >= DLY_W'(DELAY_WORDS);

	// tap address wraps below zero
	always_comb begin
		rd_sum = (AW+1)'(wptr_q) + (AW+1)'(DELAY_WORDS) - (AW+1)'(delay_q);
		if (rd_sum >= (AW+1)'(DELAY_WORDS)) begin
			rd_sum = rd_sum - (AW+1)'(DELAY_WORDS);
		end
		rd_addr = rd_sum[AW-1:0];
	end

	assign out_free = !out_valid_q || mixed.ready;
	assign wet_word = rvalid_q ? rdata_q : '0;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (samples.valid) state_d = ST_INDEX;
			ST_INDEX:  state_d = ST_LFO;
			ST_LFO:    state_d = ST_FACTOR;
			ST_FACTOR: state_d = ST_DELAY;
			ST_DELAY:  if (bcnt_q == '0) state_d = ST_REDUCE;
			ST_REDUCE: if (!delay_big) state_d = ST_READ;
			ST_READ:   state_d = ST_WRITE;
			ST_WRITE:  state_d = ST_MIX;
			ST_MIX:    if (mix_stat.done) state_d = ST_DONE;
			ST_DONE:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready  = 1'b0;
		mix_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE:  in_ready = 1'b1;
			ST_WRITE: mix_start = 1'b1;
			ST_DONE:  out_load = out_free;
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			phase_step_q <= PHASE_STEP_RST;
			mod_depth_q  <= MOD_DEPTH_RST;
			base_delay_q <= BASE_DELAY_RST;
			phase_q      <= '0;
			wptr_q       <= '0;
			wrapped_q    <= 1'b0;
			out_valid_q  <= 1'b0;
			bcnt_q       <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				case (cfg_idx)
					REG_PHASE_STEP: phase_step_q <= cfg_data[PHASE_STEP_W-1:0];
					REG_MOD_DEPTH:  mod_depth_q  <= cfg_data[MOD_DEPTH_W-1:0];
					REG_BASE_DELAY: base_delay_q <= cfg_data[BASE_DELAY_W-1:0];
					default: begin
					end
				endcase
			end
			if (state_q == ST_INDEX) begin
				phase_q <= phase_q + 32'(phase_step_q);
			end
			if (state_q == ST_FACTOR) begin
				bcnt_q <= BCW'(BASE_DELAY_W - 1);
			end else if (state_q == ST_DELAY) begin
				bcnt_q <= bcnt_q - 1'b1;
			end
			if (state_q == ST_WRITE) begin
				if (wptr_q == AW'(DELAY_WORDS - 1)) begin
					wptr_q    <= '0;
					wrapped_q <= 1'b1;
				end else begin
					wptr_q <= wptr_q + 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (mixed.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && samples.valid) begin
			dry_q <= samples.in_sample;
		end
		case (state_q)
			ST_INDEX: begin
				neg_q <= phase_q[31];
				idx_q <= phase_q[30] ? IW'(SINE_QUARTER_ENTRIES) - idx_raw : idx_raw;
			end
			ST_LFO: begin
				lfo_q <= neg_q ? -$signed({1'b0, sine_rom[idx_q]})
					: $signed({1'b0, sine_rom[idx_q]});
			end
			ST_FACTOR: begin
				// a negative factor clamps the delay to zero
				factor_q  <= factor_sum[33] ? '0 : factor_sum[FACTOR_W-1:0];
				prod_q    <= '0;
				base_sr_q <= base_delay_q;
			end
			ST_DELAY: begin
				prod_q    <= prod_next;
				base_sr_q <= base_sr_q << 1;
				delay_q   <= DLY_W'(prod_next[PRODW-1:30]);
			end
			ST_REDUCE: begin
				if (delay_big) begin
					delay_q <= delay_q - DLY_W'(DELAY_WORDS);
				end
			end
			ST_READ: begin
				rdata_q  <= mem[rd_addr];
				// words not yet written since reset read as zero
				rvalid_q <= wrapped_q || (rd_addr < wptr_q);
			end
			ST_WRITE: begin
				mem[wptr_q] <= dry_q;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_data_q <= mix_result;
		end
	end

	mdc_serial_mix #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_mix (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mix_start),
		.dry    (dry_q),
		.wet    (wet_word),
		.stat   (mix_stat),
		.result (mix_result)
	);

	assign samples.ready    = in_ready;
	assign mixed.valid      = out_valid_q;
	assign mixed.out_sample = out_data_q;

	`MDC_ASSERT_NOW(a_done_in_mix, mix_stat.done, state_q == ST_MIX,
		"mixer finished outside the mix step")
	`MDC_ASSERT_NOW(a_busy_in_mix, mix_stat.busy, state_q == ST_MIX,
		"mixer shifting outside the mix step")
	`MDC_ASSERT_NEXT(a_hold_result, state_q == ST_DONE && out_valid_q && !mixed.ready,
		state_q == ST_DONE && out_valid_q, "pending result overwritten")
	`MDC_ASSERT_NOW(a_tap_in_range, state_q == ST_READ, !delay_big,
		"delay not reduced before the read")
	`MDC_ASSERT_NOW(a_wptr_in_range, 1'b1, (AW+1)'(wptr_q) < (AW+1)'(DELAY_WORDS),
		"write pointer past the delay line")

endmodule

[dv/modulated_delay_chorus_checker.sv]
// checker for the chorus: watches both streams and the register port, predicts and compares
module modulated_delay_chorus_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr,
	input  logic [mdc_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [mdc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic [mdc_pkg::SAMPLE_BITS_DEF-1:0] in_sample,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic [mdc_pkg::SAMPLE_BITS_DEF-1:0] out_sample,
	output int                                 outstanding,
	output int                                 fail_count
);
	import mdc_pkg::*;

	localparam int WORDS = DELAY_WORDS_DEF;
	localparam int PTR_W = $clog2(WORDS);
	localparam int SB    = SAMPLE_BITS_DEF;
	localparam int QN    = SINE_QUARTER_ENTRIES_DEF;

	logic [PHASE_STEP_W-1:0] step_q;
	logic [MOD_DEPTH_W-1:0]  depth_q;
	logic [BASE_DELAY_W-1:0] centre_q;
	logic [SB-1:0]           line_mem [WORDS];
	logic [PTR_W-1:0]        head;
	logic [31:0]             phase;
	int                      sine_tab [0:QN];
	logic [SB-1:0]           pending_mix [$];
	logic [SB-1:0]           want;
	int                      fails = 0;

	assign fail_count = fails;

	// quarter-wave entry in q15, taylor series in q30
	function automatic int quarter_sine(input int k);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint          sum;
		x    = (longint'(k) * HALF_PI_Q30) / QN;
		x2   = (x * x) >> 30;
		term = x;
		sum  = longint'(x);
		for (int n = 1; n <= 6; n++) begin
			term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				sum -= longint'(term);
			end else begin
				sum += longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > (64'sd1 << 30)) begin
			sum = 64'sd1 << 30;
		end
		return int'((sum * 32767 + (64'sd1 << 29)) >>> 30);
	endfunction

	// one chorus step: delay tap from the lfo, read before write, q15 mix
	function automatic logic [SB-1:0] chorus_mix(input logic [SB-1:0] dry_bits);
		logic [1:0]        quad;
		longint unsigned   idx;
		longint            lfo;
		longint            factor;
		longint unsigned   tap;
		logic [PTR_W-1:0]  rd;
		longint            dry;
		longint            wet;
		longint            acc;
		quad = phase[31:30];
		idx  = (64'(phase[29:0]) * QN) >> 30;
		if (quad[0]) begin
			idx = QN - idx;
		end
		lfo = sine_tab[idx];
		if (quad[1]) begin
			lfo = -lfo;
		end
		phase  = phase + 32'(step_q);
		factor = (64'sd1 << 30) + lfo * longint'(depth_q);
		if (factor < 0) begin
			factor = 0;
		end
		tap = (longint'(centre_q) * factor) >> 30;
		rd  = head - tap[PTR_W-1:0];
		dry = longint'(signed'(dry_bits));
		wet = longint'(signed'(line_mem[rd]));
		line_mem[head] = dry_bits;
		head = head + 1'b1;
		acc = W_DRY * dry + W_WET * wet + MIX_ROUND;
		acc = acc >>> MIX_SHIFT;
		return acc[SB-1:0];
	endfunction

	task automatic note_failure(input string msg);
		fails++;
		if (fails <= 10) begin
			$display("%s", msg);
		end
	endtask

	initial begin
		for (int k = 0; k <= QN; k++) begin
			sine_tab[k] = quarter_sine(k);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   = PHASE_STEP_RST;
			depth_q  = MOD_DEPTH_RST;
			centre_q = BASE_DELAY_RST;
			foreach (line_mem[w]) begin
				line_mem[w] = '0;
			end
			head  = '0;
			phase = '0;
			pending_mix.delete();
			outstanding <= 0;
		end else begin
			if (cfg_wr) begin
				case (cfg_idx)
					REG_PHASE_STEP: step_q   = cfg_data[PHASE_STEP_W-1:0];
					REG_MOD_DEPTH:  depth_q  = cfg_data[MOD_DEPTH_W-1:0];
					REG_BASE_DELAY: centre_q = cfg_data[BASE_DELAY_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				pending_mix = {pending_mix, chorus_mix(in_sample)};
			end
			if (out_valid && out_ready) begin
				if (pending_mix.size() == 0) begin
					note_failure($sformatf("unexpected out_sample %0d with no request pending",
						$signed(out_sample)));
				end else begin
					want = pending_mix.pop_front();
					if (want !== out_sample) begin
						note_failure($sformatf("out_sample mismatch: expected %0d got %0d",
							$signed(want), $signed(out_sample)));
					end
				end
			end
			outstanding <= pending_mix.size();
		end
	end

endmodule

[dv/modulated_delay_chorus_tb.sv]
// top of the chorus testbench: clock, reset, register writes, sample stimulus and verdict
module modulated_delay_chorus_tb;
	import mdc_pkg::*;

	localparam int SB           = SAMPLE_BITS_DEF;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int PHASES       = 8;
	localparam int BATCH        = 182;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 100;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam logic [SB-1:0] CORNERS [9] = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF,
		24'h000001, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	int outstanding;
	int fail_count;
	int cycle_count   = 0;
	int samples_sent  = 0;
	int settings_used = 0;
	bit tx_idle       = 1'b1;
	bit rx_idle       = 1'b1;
	bit hold_req      = 1'b0;
	int hold_left     = 0;

	mdc_in_if  samples_ch ();
	mdc_out_if mixed_ch ();

	modulated_delay_chorus i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr   (cfg_wr),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.samples  (samples_ch),
		.mixed    (mixed_ch)
	);

	modulated_delay_chorus_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr      (cfg_wr),
		.cfg_idx     (cfg_idx),
		.cfg_data    (cfg_data),
		.in_valid    (samples_ch.valid),
		.in_ready    (samples_ch.ready),
		.in_sample   (samples_ch.in_sample),
		.out_valid   (mixed_ch.valid),
		.out_ready   (mixed_ch.ready),
		.out_sample  (mixed_ch.out_sample),
		.outstanding (outstanding),
		.fail_count  (fail_count)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("modulated_delay_chorus_tb: errors");
			$finish;
		end
	end

	// output side: random stalls plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			mixed_ch.ready <= 1'b0;
		end else begin
			mixed_ch.ready <= !(rx_idle && $urandom_range(99) < 6);
		end
	end

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_wr   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_wr <= 1'b0;
	endtask

	task automatic offer(input logic [SB-1:0] value);
		@(negedge clk);
		while (tx_idle && $urandom_range(99) < 6) begin
			samples_ch.valid <= 1'b0;
			@(negedge clk);
		end
		samples_ch.valid     <= 1'b1;
		samples_ch.in_sample <= value;
		do begin
			@(posedge clk);
		end while (!samples_ch.ready);
		samples_sent++;
	endtask

	// stop offering and wait for every mixed sample to come back
	task automatic drain();
		@(negedge clk);
		samples_ch.valid <= 1'b0;
		while (outstanding != 0) begin
			@(posedge clk);
		end
	endtask

	function automatic logic [SB-1:0] pick_sample();
		case ($urandom_range(15))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return '0;
			3: return '1;
			default: return SB'($urandom);
		endcase
	endfunction

	// random setting, extremes weighted in; spare upper data bits carry junk
	task automatic retune();
		logic [CFG_DATA_W-1:0] step;
		logic [CFG_DATA_W-1:0] depth;
		logic [CFG_DATA_W-1:0] centre;
		step   = CFG_DATA_W'($urandom);
		depth  = CFG_DATA_W'($urandom);
		centre = CFG_DATA_W'($urandom);
		case ($urandom_range(3))
			0: step = '0;
			1: step = '1;
			2: step = CFG_DATA_W'($urandom_range(200000));
			default: ;
		endcase
		case ($urandom_range(3))
			0: depth[MOD_DEPTH_W-1:0] = '0;
			1: depth[MOD_DEPTH_W-1:0] = 16'd32768;
			2: depth[MOD_DEPTH_W-1:0] = 16'hFFFF;
			default: ;
		endcase
		case ($urandom_range(4))
			0: centre[BASE_DELAY_W-1:0] = '0;
			1: centre[BASE_DELAY_W-1:0] = 10'd1;
			2: centre[BASE_DELAY_W-1:0] = 10'd1023;
			3: centre[BASE_DELAY_W-1:0] = BASE_DELAY_W'($urandom_range(64, 1));
			default: ;
		endcase
		put_reg(REG_PHASE_STEP, step);
		put_reg(REG_MOD_DEPTH, depth);
		put_reg(REG_BASE_DELAY, centre);
		if ($urandom_range(1) == 1) begin
			put_reg(REG_SPARE, CFG_DATA_W'($urandom));
		end
		settings_used++;
	endtask

	initial begin
		arst_n               = 1'b0;
		cfg_wr               = 1'b0;
		cfg_idx              = REG_PHASE_STEP;
		cfg_data             = '0;
		samples_ch.valid     = 1'b0;
		samples_ch.in_sample = '0;
		mixed_ch.ready       = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset setting
		offer(24'h7FFFFF);
		offer(24'h800000);
		drain();

		// one-sample delay, no sweep: wet is the previous request
		put_reg(REG_PHASE_STEP, '0);
		put_reg(REG_MOD_DEPTH, '0);
		put_reg(REG_BASE_DELAY, 23'd1);
		settings_used += 2;
		foreach (CORNERS[i]) begin
			offer(CORNERS[i]);
		end
		drain();

		// zero delay reads the word from a full line earlier
		put_reg(REG_BASE_DELAY, '0);
		settings_used++;
		offer(24'h7FFFFF);
		offer(24'h800000);
		offer(pick_sample());
		drain();

		// over-range depth, widest step and centre, spare index ignored
		put_reg(REG_PHASE_STEP, '1);
		put_reg(REG_MOD_DEPTH, 23'h00FFFF);
		put_reg(REG_BASE_DELAY, 23'h0003FF);
		put_reg(REG_SPARE, '1);
		settings_used++;
		repeat (6) offer(pick_sample());
		drain();

		// full depth
		put_reg(REG_MOD_DEPTH, 23'd32768);
		put_reg(REG_PHASE_STEP, 23'h400000);
		settings_used++;
		repeat (5) offer(pick_sample());

		for (int p = 0; p < PHASES; p++) begin
			drain();
			retune();
			tx_idle = (p != 1);
			rx_idle = (p != 1);
			for (int i = 0; i < BATCH; i++) begin
				offer(pick_sample());
				if (p == 4 && i == 20) begin
					hold_req = 1'b1;
				end
			end
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("chorus run: %0d samples over %0d register settings", samples_sent,
			settings_used);
		$display("  zero and one-sample delay, full and over-range depth, long output stall");
		if (fail_count == 0 && outstanding == 0) begin
			$display("modulated_delay_chorus_tb: clean");
		end else begin
			$display("modulated_delay_chorus_tb: errors");
		end
		$finish;
	end

endmodule
